[hw/rtl/crfw_pkg.sv]
// ----------------------------------------------------------------------------
// crfw_pkg: shared types and constants for the COBS ring frame writer
// Index widths, action and result codes, and the command that the front
// hands to the back through the queue.
// ----------------------------------------------------------------------------
`default_nettype none

package crfw_pkg;

    // Ring geometry
    localparam int RING_DEPTH = 1024;
    localparam int IDX_W      = 10;
    localparam int SIZE_W     = 11;
    localparam int BYTE_W     = 8;
    localparam int MAX_SIZE   = (RING_DEPTH < 1024) ? RING_DEPTH : 1024;
    localparam logic [SIZE_W-1:0] TOP_SIZE   = SIZE_W'(MAX_SIZE);
    localparam logic [SIZE_W-1:0] MIN_SIZE   = SIZE_W'(2);
    localparam logic [SIZE_W-1:0] RESET_SIZE = SIZE_W'(1024);
    localparam logic [BYTE_W-1:0] MAX_CODE   = 8'hFF;

    // Results per item and the queue between front and back
    localparam int MAX_RESULTS = 4;
    localparam int RES_IDX_W   = $clog2(MAX_RESULTS);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        ACT_OPEN   = 2'd0,
        ACT_DATA   = 2'd1,
        ACT_COMMIT = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        KIND_WRITE   = 2'd0,
        KIND_PUBLISH = 2'd1,
        KIND_REJECT  = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [IDX_W-1:0]   slot_address;
        logic [BYTE_W-1:0]  slot_value;
    } t_result;

    typedef struct packed {
        t_result [MAX_RESULTS-1:0]  res;
        logic [RES_IDX_W-1:0]       last_idx;
    } t_cmd;

    typedef struct packed {
        logic               full;
        logic               empty;
        logic [QCNT_W-1:0]  count;
    } t_q_status;

endpackage

`default_nettype wire

[hw/rtl/crfw_in_if.sv]
// ----------------------------------------------------------------------------
// crfw_in_if: input channel of the COBS ring frame writer
// One item is an action, a payload byte and the reader position.
// ----------------------------------------------------------------------------
`default_nettype none

interface crfw_in_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    action;
    logic [crfw_pkg::BYTE_W-1:0]   data_byte;
    logic [crfw_pkg::IDX_W-1:0]    reader_index;

    modport source (output valid, output action, output data_byte,
                    output reader_index, input ready);
    modport sink   (input valid, input action, input data_byte,
                    input reader_index, output ready);
endinterface

`default_nettype wire

[hw/rtl/crfw_out_if.sv]
// ----------------------------------------------------------------------------
// crfw_out_if: result channel of the COBS ring frame writer
// One item is a ring write, a publish or a rejection notice.
// ----------------------------------------------------------------------------
`default_nettype none

interface crfw_out_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    kind;
    logic [crfw_pkg::IDX_W-1:0]    slot_address;
    logic [crfw_pkg::BYTE_W-1:0]   slot_value;
    logic                          last;

    modport source (output valid, output kind, output slot_address,
                    output slot_value, output last, input ready);
    modport sink   (input valid, input kind, input slot_address,
                    input slot_value, input last, output ready);
endinterface

`default_nettype wire

[hw/rtl/crfw_cfg_if.sv]
// ----------------------------------------------------------------------------
// crfw_cfg_if: configuration write channel
// Carries the ring size register value.
// ----------------------------------------------------------------------------
`default_nettype none

interface crfw_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [crfw_pkg::SIZE_W-1:0]   ring_size;

    modport source (output valid, output ring_size, input ready);
    modport sink   (input valid, input ring_size, output ready);
endinterface

`default_nettype wire

[hw/rtl/crfw_front.sv]
// ----------------------------------------------------------------------------
// crfw_front: accept and classify actions
// Holds the ring pointers and frame state, runs the full checks and builds
// the list of results for one item combinationally.
// ----------------------------------------------------------------------------
`default_nettype none

module crfw_front (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    crfw_in_if.sink             i_in,
    crfw_cfg_if.sink            i_cfg,
    output logic                o_push_valid,
    output crfw_pkg::t_cmd      o_push_cmd,
    input  wire                 i_push_ready
);
    import crfw_pkg::*;

    logic [SIZE_W-1:0]  r_ring_size;
    logic [IDX_W-1:0]   r_marker, n_marker;
    logic [IDX_W-1:0]   r_write, n_write;
    logic               r_open, n_open;

    logic [SIZE_W-1:0]  eff_size;
    logic [IDX_W-1:0]   np_w, np_w2;
    logic [BYTE_W-1:0]  d_w, d_w2;
    logic               blk_w, blk_w2, accept;
    t_cmd               cmd;
    logic               has_res;

    function automatic logic [IDX_W-1:0] next_pos(input logic [IDX_W-1:0] p,
                                                  input logic [SIZE_W-1:0] s);
        logic [SIZE_W-1:0] n;
        n = {1'b0, p} + SIZE_W'(1);
        if (n >= s) n = '0;
        return n[IDX_W-1:0];
    endfunction

    function automatic logic [BYTE_W-1:0] block_dist(input logic [IDX_W-1:0] m,
                                                     input logic [IDX_W-1:0] w,
                                                     input logic [SIZE_W-1:0] s);
        logic [SIZE_W-1:0] d;
        if (m > w) d = s - {1'b0, m} + {1'b0, w};
        else       d = {1'b0, w} - {1'b0, m};
        return d[BYTE_W-1:0];
    endfunction

    function automatic t_result mk(input t_kind k, input logic [IDX_W-1:0] a,
                                   input logic [BYTE_W-1:0] v);
        t_result r;
        r.kind         = k;
        r.slot_address = a;
        r.slot_value   = v;
        return r;
    endfunction

    assign i_cfg.ready  = 1'b1;
    assign accept       = i_in.valid && i_push_ready;
    assign i_in.ready   = i_push_ready;
    assign o_push_valid = accept && has_res;
    assign o_push_cmd   = cmd;

    // Clamp the ring size and precompute positions and distances
    always_comb begin
        if (r_ring_size < MIN_SIZE)      eff_size = MIN_SIZE;
        else if (r_ring_size > TOP_SIZE) eff_size = TOP_SIZE;
        else                             eff_size = r_ring_size;
        np_w   = next_pos(r_write, eff_size);
        np_w2  = next_pos(np_w, eff_size);
        d_w    = block_dist(r_marker, r_write, eff_size);
        d_w2   = block_dist(r_marker, np_w, eff_size);
        blk_w  = (i_in.reader_index == np_w);
        blk_w2 = (i_in.reader_index == np_w2);
    end

    // Classify the action and build its results
    always_comb begin
        n_marker = r_marker;
        n_write  = r_write;
        n_open   = r_open;
        cmd      = '0;
        has_res  = 1'b0;
        case (i_in.action)
            ACT_OPEN: begin
                if (!r_open) begin
                    has_res = 1'b1;
                    if (blk_w) begin
                        cmd.res[0] = mk(KIND_REJECT, r_write, '0);
                    end else begin
                        cmd.res[0] = mk(KIND_WRITE, r_write, '0);
                        n_marker   = r_write;
                        n_write    = np_w;
                        n_open     = 1'b1;
                    end
                end
            end
            ACT_DATA: begin
                if (r_open) begin
                    has_res = 1'b1;
                    if (blk_w) begin
                        cmd.res[0] = mk(KIND_REJECT, r_marker, '0);
                    end else if (i_in.data_byte == '0) begin
                        // zero byte closes the block
                        cmd.res[0]   = mk(KIND_WRITE, r_marker, d_w);
                        cmd.res[1]   = mk(KIND_WRITE, r_write, '0);
                        cmd.last_idx = RES_IDX_W'(1);
                        n_marker     = r_write;
                        n_write      = np_w;
                    end else if (d_w2 == MAX_CODE && blk_w2) begin
                        cmd.res[0] = mk(KIND_REJECT, r_marker, '0);
                    end else begin
                        cmd.res[0] = mk(KIND_WRITE, r_write, i_in.data_byte);
                        n_write    = np_w;
                        if (d_w2 == MAX_CODE) begin
                            // full run closes the block after the byte
                            cmd.res[1]   = mk(KIND_WRITE, r_marker, d_w2);
                            cmd.res[2]   = mk(KIND_WRITE, np_w, '0);
                            cmd.last_idx = RES_IDX_W'(2);
                            n_marker     = np_w;
                            n_write      = np_w2;
                        end
                    end
                end
            end
            ACT_COMMIT: begin
                if (r_open) begin
                    has_res = 1'b1;
                    if (blk_w) begin
                        cmd.res[0] = mk(KIND_REJECT, r_marker, '0);
                    end else begin
                        cmd.res[0]   = mk(KIND_WRITE, r_marker, d_w);
                        cmd.res[1]   = mk(KIND_WRITE, r_write, '0);
                        cmd.res[2]   = mk(KIND_PUBLISH, np_w, '0);
                        cmd.last_idx = RES_IDX_W'(2);
                        n_marker     = r_write;
                        n_write      = np_w;
                        n_open       = 1'b0;
                    end
                end
            end
            default: begin
                has_res = 1'b0;
            end
        endcase
    end

    // Hold the ring size register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_size <= RESET_SIZE;
        end else if (i_cfg.valid) begin
            r_ring_size <= i_cfg.ring_size;
        end
    end

    // Advance the frame state on each accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_marker <= '0;
            r_write  <= '0;
            r_open   <= 1'b0;
        end else if (accept) begin
            r_marker <= n_marker;
            r_write  <= n_write;
            r_open   <= n_open;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/crfw_queue.sv]
// ----------------------------------------------------------------------------
// crfw_queue: command queue between front and back
// Small register FIFO of result lists so both sides stall on their own.
// ----------------------------------------------------------------------------
`default_nettype none

module crfw_queue (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_push_valid,
    input  crfw_pkg::t_cmd          i_push_cmd,
    output logic                    o_push_ready,
    output logic                    o_head_valid,
    output crfw_pkg::t_cmd          o_head_cmd,
    input  wire                     i_pop,
    output crfw_pkg::t_q_status     o_status
);
    import crfw_pkg::*;

    t_cmd               r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;
    logic               do_push, do_pop;

    assign o_push_ready    = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_head_valid    = (r_count != '0);
    assign o_head_cmd      = r_mem[r_rd_ptr];
    assign do_push         = i_push_valid && o_push_ready;
    assign do_pop          = i_pop && o_head_valid;
    assign o_status.full   = !o_push_ready;
    assign o_status.empty  = !o_head_valid;
    assign o_status.count  = r_count;

    // Store pushed commands
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            if (do_pop)  r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            if (do_push && !do_pop)      r_count <= r_count + QCNT_W'(1);
            else if (do_pop && !do_push) r_count <= r_count - QCNT_W'(1);
        end
    end

endmodule

`default_nettype wire

[hw/rtl/crfw_back.sv]
// ----------------------------------------------------------------------------
// crfw_back: emit results
// Walks the queue head's results, one per cycle while the output is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module crfw_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_head_valid,
    input  crfw_pkg::t_cmd      i_head_cmd,
    output logic                o_pop,
    crfw_out_if.source          o_out
);
    import crfw_pkg::*;

    logic [RES_IDX_W-1:0]   r_idx, n_idx;
    t_result                cur;
    logic                   is_last, fire;

    assign cur                = i_head_cmd.res[r_idx];
    assign is_last            = (r_idx == i_head_cmd.last_idx);
    assign fire               = o_out.valid && o_out.ready;
    assign o_out.valid        = i_head_valid;
    assign o_out.kind         = cur.kind;
    assign o_out.slot_address = cur.slot_address;
    assign o_out.slot_value   = cur.slot_value;
    assign o_out.last         = is_last;
    assign o_pop              = fire && is_last;

    // Step through the list, restart at the next command
    always_comb begin
        n_idx = r_idx;
        if (fire) n_idx = is_last ? '0 : r_idx + RES_IDX_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else begin
            r_idx <= n_idx;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/cobs_ring_frame_writer_top.sv]
// ----------------------------------------------------------------------------
// cobs_ring_frame_writer_top: COBS frame writer into a ring buffer
// Front classifies actions, a two-entry queue decouples it from the back,
// which streams the ring writes and publishes.
// ----------------------------------------------------------------------------
// The front takes one action item per cycle unless the queue is full and
// turns it into up to three result items (none when the action is ignored;
// otherwise a rejection, ring writes with the back-patched code and
// delimiter, and the publish on commit); the back sends them one per cycle
// while the result port is ready, so the sustained rate is set by that single
// result port. A two-entry command queue lets new items enter while results
// are still draining. The ring size register is written over its own
// channel, only while the block is idle, as a rule for the user that the
// block itself does not enforce; there is no start-up clearing pass.
`default_nettype none

module cobs_ring_frame_writer_top (
    input  wire         i_clk,
    input  wire         i_rst_n,
    crfw_in_if.sink     i_in,
    crfw_cfg_if.sink    i_cfg,
    crfw_out_if.source  o_out
);
    import crfw_pkg::*;

    logic       push_valid, push_ready, head_valid, pop;
    t_cmd       push_cmd, head_cmd;
    t_q_status  q_status;

    crfw_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_cfg        (i_cfg),
        .o_push_valid (push_valid),
        .o_push_cmd   (push_cmd),
        .i_push_ready (push_ready)
    );

    crfw_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_cmd   (push_cmd),
        .o_push_ready (push_ready),
        .o_head_valid (head_valid),
        .o_head_cmd   (head_cmd),
        .i_pop        (pop),
        .o_status     (q_status)
    );

    crfw_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head_cmd   (head_cmd),
        .o_pop        (pop),
        .o_out        (o_out)
    );

    // A rejection is always the only result of its item
    a_reject_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.kind == KIND_REJECT) |-> o_out.last)
        else $error("rejection not marked last");

    // A publish always ends its item
    a_publish_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.kind == KIND_PUBLISH) |-> o_out.last)
        else $error("publish not marked last");

    // No result without a queued command
    a_empty_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_status.empty |-> !o_out.valid)
        else $error("result shown with empty queue");

    // Full queue stops the input
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_status.full |-> !i_in.ready)
        else $error("input ready while queue full");

endmodule

`default_nettype wire

[verif/crfw_frame_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// crfw_frame_checker: result checker for the COBS ring frame writer
// Watches the action, configuration and result channels, keeps its own copy
// of the encoder state, queues the results each accepted action should
// cause, and compares every accepted result with the oldest queued one.
// ----------------------------------------------------------------------------
module crfw_frame_checker (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    crfw_in_if                           i_in,
    crfw_cfg_if                          i_cfg,
    crfw_out_if                          i_out,
    output int                           o_fail_count,
    output int                           o_checked_count,
    output int                           o_reject_count,
    output int                           o_outstanding,
    output logic [crfw_pkg::IDX_W-1:0]   o_write_pos,
    output logic [crfw_pkg::SIZE_W-1:0]  o_ring_slots
);
    import crfw_pkg::*;

    // Stop printing details after this many failures
    localparam int REPORT_LIMIT = 60;

    typedef struct packed {
        t_kind              kind;
        logic [IDX_W-1:0]   slot;
        logic [BYTE_W-1:0]  value;
        logic               last;
    } t_ring_op;

    t_ring_op           ring_ops_q[$];
    t_ring_op           got;
    t_ring_op           want;
    logic [SIZE_W-1:0]  size_reg;
    logic [IDX_W-1:0]   marker_pos;
    logic [IDX_W-1:0]   write_pos;
    logic               frame_active;
    int                 fails = 0;
    int                 checked = 0;
    int                 rejects = 0;

    // Clamp the size register to the usable range
    function automatic logic [SIZE_W-1:0] slots_in_use();
        logic [SIZE_W-1:0] s;
        s = size_reg;
        if (s < MIN_SIZE) s = MIN_SIZE;
        if (s > TOP_SIZE) s = TOP_SIZE;
        return s;
    endfunction

    // Step one slot forward, wrapping at the ring size
    function automatic logic [IDX_W-1:0] advance(input logic [IDX_W-1:0] p);
        logic [SIZE_W-1:0] n;
        n = SIZE_W'(p) + 1'b1;
        if (n >= slots_in_use()) n = '0;
        return n[IDX_W-1:0];
    endfunction

    // Code byte for a block running from the marker up to a write position
    function automatic logic [BYTE_W-1:0] code_between(input logic [IDX_W-1:0] from_pos,
                                                       input logic [IDX_W-1:0] to_pos);
        int d;
        if (from_pos > to_pos)
            d = int'(slots_in_use()) - int'(from_pos) + int'(to_pos);
        else
            d = int'(to_pos) - int'(from_pos);
        return d[7:0];
    endfunction

    function automatic void queue_op(input t_kind k, input logic [IDX_W-1:0] a,
                                     input logic [BYTE_W-1:0] v);
        t_ring_op op;
        op.kind  = k;
        op.slot  = a;
        op.value = v;
        op.last  = 1'b0;
        ring_ops_q.push_back(op);
    endfunction

    // Patch the code into the marker slot and open a new block behind it
    function automatic void close_code_block();
        queue_op(KIND_WRITE, marker_pos, code_between(marker_pos, write_pos));
        marker_pos = write_pos;
        queue_op(KIND_WRITE, marker_pos, '0);
        write_pos = advance(write_pos);
    endfunction

    // Work out the results of one accepted action and advance the state
    function automatic void predict_action(input logic [1:0] act,
                                           input logic [BYTE_W-1:0] val,
                                           input logic [IDX_W-1:0] rdr);
        int                before_n;
        logic [IDX_W-1:0]  w2;
        t_ring_op          tail;
        before_n = ring_ops_q.size();
        case (act)
            ACT_OPEN: begin
                if (!frame_active) begin
                    if (rdr == advance(write_pos)) begin
                        queue_op(KIND_REJECT, write_pos, '0);
                    end else begin
                        marker_pos = write_pos;
                        queue_op(KIND_WRITE, marker_pos, '0);
                        write_pos = advance(marker_pos);
                        frame_active = 1'b1;
                    end
                end
            end
            ACT_DATA: begin
                if (frame_active) begin
                    w2 = advance(write_pos);
                    if (rdr == w2) begin
                        queue_op(KIND_REJECT, marker_pos, '0);
                    end else if (val == '0) begin
                        close_code_block();
                    end else if (code_between(marker_pos, w2) == MAX_CODE
                                 && rdr == advance(w2)) begin
                        // full block would also need the slot after it
                        queue_op(KIND_REJECT, marker_pos, '0);
                    end else begin
                        queue_op(KIND_WRITE, write_pos, val);
                        write_pos = w2;
                        if (code_between(marker_pos, write_pos) == MAX_CODE)
                            close_code_block();
                    end
                end
            end
            ACT_COMMIT: begin
                if (frame_active) begin
                    if (rdr == advance(write_pos)) begin
                        queue_op(KIND_REJECT, marker_pos, '0);
                    end else begin
                        close_code_block();
                        queue_op(KIND_PUBLISH, write_pos, '0);
                        frame_active = 1'b0;
                    end
                end
            end
            default: ;
        endcase
        // Flag the final result of the item
        if (ring_ops_q.size() > before_n) begin
            tail = ring_ops_q.pop_back();
            tail.last = 1'b1;
            ring_ops_q.push_back(tail);
        end
    endfunction

    // Compare one accepted result with the oldest pending one
    function automatic void check_result();
        got.kind  = t_kind'(i_out.kind);
        got.slot  = i_out.slot_address;
        got.value = i_out.slot_value;
        got.last  = i_out.last;
        checked++;
        if (got.kind == KIND_REJECT) rejects++;
        if (ring_ops_q.size() == 0) begin
            fails++;
            if (fails <= REPORT_LIMIT)
                $display({"%0t: result with nothing pending: kind %0d slot %0d",
                          " value 0x%02h last %0b"},
                         $time, got.kind, got.slot, got.value, got.last);
        end else begin
            want = ring_ops_q.pop_front();
            if (got.kind !== want.kind || got.slot !== want.slot
                || got.value !== want.value || got.last !== want.last) begin
                fails++;
                if (fails <= REPORT_LIMIT)
                    $display({"%0t: result mismatch: expected kind %0d slot %0d value 0x%02h",
                              " last %0b, got kind %0d slot %0d value 0x%02h last %0b"},
                             $time, want.kind, want.slot, want.value, want.last,
                             got.kind, got.slot, got.value, got.last);
            end
        end
    endfunction

    // Check results first, then apply configuration, then predict new items
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            size_reg     = RESET_SIZE;
            marker_pos   = '0;
            write_pos    = '0;
            frame_active = 1'b0;
            ring_ops_q.delete();
        end else begin
            if (i_out.valid && i_out.ready)
                check_result();
            if (i_cfg.valid && i_cfg.ready)
                size_reg = i_cfg.ring_size;
            if (i_in.valid && i_in.ready)
                predict_action(i_in.action, i_in.data_byte, i_in.reader_index);
        end
        o_fail_count    <= fails;
        o_checked_count <= checked;
        o_reject_count  <= rejects;
        o_outstanding   <= ring_ops_q.size();
        o_write_pos     <= write_pos;
        o_ring_slots    <= slots_in_use();
    end

endmodule

[verif/cobs_ring_frame_writer_top_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cobs_ring_frame_writer_top_test: regression for the COBS ring frame writer
// Drives action items with random gaps and result back-pressure, steers the
// reader position just past the write position to force full-ring rejections,
// walks the ring size through its extremes, and leaves result checking to the
// frame checker beside the block.
// ----------------------------------------------------------------------------
module cobs_ring_frame_writer_top_test;
    import crfw_pkg::*;

    localparam int          STALL_LIMIT = 5000;
    localparam int          HOLD_CYCLES = 200;
    localparam int          PHASE_ITEMS = 16;
    localparam int          LONG_RUN    = 258;
    localparam int          N_SIZES     = 9;
    localparam logic [1:0]  ACT_UNUSED  = 2'd3;
    localparam logic [SIZE_W-1:0] SIZE_PLAN [N_SIZES] = '{
        11'd1024, 11'd2047, 11'd300, 11'd0, 11'd1, 11'd2, 11'd3, 11'd17, 11'd1024
    };

    logic               clk;
    logic               rst_n;
    int                 send_idle_pct;
    int                 recv_idle_pct;
    int                 hold_gen;
    int                 items_sent = 0;
    int                 stall_cycles = 0;
    int                 fail_count;
    int                 checked_count;
    int                 reject_count;
    int                 outstanding;
    logic [IDX_W-1:0]   write_pos_seen;
    logic [SIZE_W-1:0]  ring_slots;

    crfw_in_if  in_ch ();
    crfw_cfg_if cfg_ch ();
    crfw_out_if out_ch ();

    cobs_ring_frame_writer_top dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    crfw_frame_checker frame_check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in            (in_ch),
        .i_cfg           (cfg_ch),
        .i_out           (out_ch),
        .o_fail_count    (fail_count),
        .o_checked_count (checked_count),
        .o_reject_count  (reject_count),
        .o_outstanding   (outstanding),
        .o_write_pos     (write_pos_seen),
        .o_ring_slots    (ring_slots)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Result side: random stalls, plus long hold-offs on request
    initial begin
        int hold_ack;
        int hold_left;
        hold_ack  = 0;
        hold_left = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_left > 0) begin
                out_ch.ready <= 1'b0;
                hold_left = hold_left - 1;
            end else if (hold_gen != hold_ack) begin
                hold_ack  = hold_gen;
                hold_left = HOLD_CYCLES;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog: end the run when no item moves on any channel for too long
    always @(posedge clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Reader position that can never block the next write
    function automatic logic [IDX_W-1:0] far_reader();
        if (ring_slots < SIZE_W'(1024))
            return IDX_W'($urandom_range(1023, ring_slots));
        return write_pos_seen + IDX_W'($urandom_range(900, 100));
    endfunction

    // Offer one item, after a random gap, and hold it until accepted
    task automatic push_item(input logic [1:0] act, input logic [BYTE_W-1:0] val,
                             input logic [IDX_W-1:0] rdr);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.action       <= act;
        in_ch.data_byte    <= val;
        in_ch.reader_index <= rdr;
        do @(posedge clk); while (!in_ch.ready);
        items_sent++;
    endtask

    // Offer an item with the reader a few slots past the write position;
    // go idle first so the checker's write position is current
    task automatic push_near(input logic [1:0] act, input logic [BYTE_W-1:0] val,
                             input int ahead);
        logic [IDX_W-1:0] pos;
        int k;
        in_ch.valid <= 1'b0;
        @(posedge clk);
        pos = write_pos_seen;
        for (k = 0; k < ahead; k++)
            pos = ((SIZE_W'(pos) + 1) >= ring_slots) ? '0 : pos + 1'b1;
        push_item(act, val, pos);
    endtask

    // Mostly a clear ring; sometimes a near-full one, then retry the item
    task automatic send_action(input logic [1:0] act, input logic [BYTE_W-1:0] val);
        if ($urandom_range(9) == 0) begin
            push_near(act, val, $urandom_range(3, 1));
            push_item(act, val, far_reader());
        end else begin
            push_item(act, val, far_reader());
        end
    endtask

    // Open, random bytes with extra zeros, and usually a commit
    task automatic random_frame(input int max_len);
        int n;
        int k;
        send_action(ACT_OPEN, BYTE_W'($urandom));
        n = $urandom_range(max_len, 0);
        for (k = 0; k < n; k++)
            send_action(ACT_DATA, ($urandom_range(4) == 0) ? '0 : BYTE_W'($urandom));
        if ($urandom_range(9) != 0)
            send_action(ACT_COMMIT, BYTE_W'($urandom));
    endtask

    // Random frames mixed with noise items
    task automatic run_phase(input int budget);
        int stop_at;
        stop_at = items_sent + budget;
        while (items_sent < stop_at) begin
            if ($urandom_range(4) == 0)
                push_item(2'($urandom), BYTE_W'($urandom), IDX_W'($urandom));
            else
                random_frame(($urandom_range(7) == 0) ? 40 : 6);
        end
    endtask

    // Stop offering and wait for every pending result
    task automatic settle();
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (8) @(posedge clk);
    endtask

    // Write the ring size, then idle so the checker's view catches up
    task automatic set_ring_size(input logic [SIZE_W-1:0] size_val);
        cfg_ch.valid     <= 1'b1;
        cfg_ch.ring_size <= size_val;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    initial begin
        int k;
        int p;
        logic [BYTE_W-1:0] val;
        in_ch.valid        <= 1'b0;
        in_ch.action       <= ACT_OPEN;
        in_ch.data_byte    <= '0;
        in_ch.reader_index <= '0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.ring_size   <= RESET_SIZE;
        rst_n              <= 1'b0;
        hold_gen           <= 0;
        recv_idle_pct      <= 76;
        send_idle_pct       = 33;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_ring_size(TOP_SIZE);

        // Actions with no frame open and the unused code are dropped
        push_item(ACT_DATA, 8'h5A, far_reader());
        push_item(ACT_COMMIT, 8'h00, far_reader());
        push_item(ACT_UNUSED, 8'hFF, 10'h3FF);
        // Open against a full ring, then for real, then again while open
        push_near(ACT_OPEN, 8'h00, 1);
        push_item(ACT_OPEN, 8'hA5, far_reader());
        push_item(ACT_OPEN, 8'h00, far_reader());
        push_item(ACT_UNUSED, 8'h00, 10'h000);
        // Zero byte closes a block; byte extremes are stored
        push_item(ACT_DATA, 8'h00, far_reader());
        push_item(ACT_DATA, 8'hFF, far_reader());
        push_item(ACT_DATA, 8'h01, far_reader());
        // Data and commit rejected by a full ring, then retried
        push_near(ACT_DATA, 8'h80, 1);
        push_item(ACT_DATA, 8'h80, far_reader());
        push_near(ACT_COMMIT, 8'h00, 1);
        push_item(ACT_COMMIT, 8'h00, far_reader());
        // Empty frame, then a frame of back-to-back zeros
        push_item(ACT_OPEN, 8'h00, far_reader());
        push_item(ACT_COMMIT, 8'hFF, 10'h3FF);
        push_item(ACT_OPEN, 8'h00, 10'h3FF);
        push_item(ACT_DATA, 8'h00, 10'h3FF);
        push_item(ACT_DATA, 8'h00, far_reader());
        push_item(ACT_COMMIT, 8'h00, far_reader());

        for (p = 0; p < N_SIZES; p++) begin
            settle();
            set_ring_size(SIZE_PLAN[p]);
            if (p == 3) begin
                send_idle_pct  = 76;
                recv_idle_pct <= 33;
            end else if (p == 6) begin
                send_idle_pct  = 0;
                recv_idle_pct <= 0;
            end
            if (p == 0) begin
                // Long run of non-zero bytes: blocks close at code 0xFF, and the
                // first such close meets a reader right behind the new marker
                push_item(ACT_COMMIT, 8'h00, far_reader());
                push_item(ACT_OPEN, 8'h00, far_reader());
                for (k = 0; k < LONG_RUN; k++) begin
                    val = BYTE_W'($urandom_range(255, 1));
                    if (k == 253)
                        push_near(ACT_DATA, val, 2);
                    push_item(ACT_DATA, val, far_reader());
                end
                push_item(ACT_COMMIT, 8'h00, far_reader());
            end
            // Hold the result side off while items keep coming
            if (p == 4)
                hold_gen <= hold_gen + 1;
            run_phase(PHASE_ITEMS);
        end
        settle();

        $display("Run covered %0d action items across %0d ring size settings,",
                 items_sent, N_SIZES + 1);
        $display("with %0d results checked, %0d of them full-ring rejections.",
                 checked_count, reject_count);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
